/* hdl/fqs_pkg.sv */
package fqs_pkg;

  localparam int TAPS_DEF = 100;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // tag that travels with each tap through the multiply-accumulate pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

/* hdl/fqs_ram.sv */
module fqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/fqs_mac.sv */
module fqs_mac (
  input  logic                clk,
  input  logic                rst,
  input  fqs_pkg::mac_ctl_t   ctl,
  input  logic signed [15:0]  coef,
  input  logic signed [15:0]  samp,
  output logic signed [15:0]  acc,
  output logic                done
);

  import fqs_pkg::*;

  mac_ctl_t            p_ctl;
  logic signed [31:0]  prod;
  logic                prod_sat;
  logic signed [15:0]  term;
  logic signed [15:0]  base;
  logic signed [16:0]  sum;
  logic signed [15:0]  acc_next;

  // product stage
  always_ff @(posedge clk) begin
    prod     <= coef * samp;
    prod_sat <= (coef == 16'sh8000) && (samp == 16'sh8000);
    if (rst) begin
      p_ctl <= '0;
    end else begin
      p_ctl <= ctl;
    end
  end

  // q15 scale: arithmetic shift by 15 fits in 16 bits once -1 * -1 is clamped
  assign term = prod_sat ? 16'sh7fff : prod[30:15];
  assign base = p_ctl.first ? 16'sh0000 : acc;
  assign sum  = {base[15], base} + {term[15], term};

  always_comb begin
    if (sum > 17'sh07fff) begin
      acc_next = 16'sh7fff;
    end else if (sum < -17'sh08000) begin
      acc_next = 16'sh8000;
    end else begin
      acc_next = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p_ctl.valid) begin
      acc <= acc_next;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_ctl.valid && p_ctl.last;
    end
  end

endmodule

/* hdl/fir_q15_saturating_per_tap.sv */
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------
// in       | in_valid / in_stall  | op, tap_index, value
// out      | out_valid / out_stall| filtered
//
// a coefficient load is written when it is accepted; a sample is worked through
// with one read of each memory and one multiply-accumulate per tap.
// rst clears the head pointer, the control and the per-entry valid bits,
// so both stores read as zero until written.
// in_stall is high while a sample is in work; a result held by out_stall
// keeps the block from finishing the next sample but not from taking loads.
module fir_q15_saturating_per_tap #(
  parameter int TAPS = fqs_pkg::TAPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [6:0]         tap_index,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] filtered
);

  import fqs_pkg::*;

  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);

  state_t            state, state_next;
  logic [AW-1:0]     head;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     k_cnt;
  logic [TAPS-1:0]   d_valid;
  logic [TAPS-1:0]   c_valid;
  logic              s1_dv;
  logic              s1_cv;
  mac_ctl_t          issue_ctl;
  mac_ctl_t          s1_ctl;
  logic              accept;
  logic              smp_we;
  logic              coef_we;
  logic [8:0]        idx_ext;
  logic [AW-1:0]     coef_waddr;
  logic [15:0]       d_rdata;
  logic [15:0]       c_rdata;
  logic signed [15:0] mac_coef;
  logic signed [15:0] mac_samp;
  logic signed [15:0] acc;
  logic              done;
  logic              issue;
  logic              out_load;
  logic              out_free;

  assign accept     = in_valid && !in_stall;
  assign smp_we     = accept && (op == OP_SAMPLE);
  assign idx_ext    = 9'(tap_index);
  assign coef_we    = accept && (op == OP_LOAD) && (idx_ext < 9'(TAPS));
  assign coef_waddr = idx_ext[AW-1:0];
  assign out_free   = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (smp_we) state_next = ST_RUN;
      ST_RUN:   if (k_cnt == LAST_ADDR) state_next = ST_DRAIN;
      ST_DRAIN: if (done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_RUN:   issue    = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load = out_free;
      default:  ;
    endcase
  end

  assign issue_ctl = '{valid: issue, first: (k_cnt == '0), last: (k_cnt == LAST_ADDR)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      d_valid <= '0;
      c_valid <= '0;
      s1_ctl  <= '0;
    end else begin
      state  <= state_next;
      s1_ctl <= issue_ctl;
      if (smp_we) begin
        d_valid[head] <= 1'b1;
        // delay line shift: the head moves back one place per sample
        head <= (head == '0) ? LAST_ADDR : head - 1'b1;
      end
      if (coef_we) begin
        c_valid[coef_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_we) begin
      rd_addr <= head;
      k_cnt   <= '0;
    end else if (issue) begin
      rd_addr <= (rd_addr == LAST_ADDR) ? '0 : rd_addr + 1'b1;
      k_cnt   <= k_cnt + 1'b1;
    end
    s1_dv <= d_valid[rd_addr];
    s1_cv <= c_valid[k_cnt];
  end

  fqs_ram #(
    .WIDTH (16),
    .DEPTH (TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (head),
    .wdata (value),
    .raddr (rd_addr),
    .rdata (d_rdata)
  );

  fqs_ram #(
    .WIDTH (16),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (value),
    .raddr (k_cnt),
    .rdata (c_rdata)
  );

  // entries never written read as zero
  assign mac_coef = s1_cv ? c_rdata : 16'sh0000;
  assign mac_samp = s1_dv ? d_rdata : 16'sh0000;

  fqs_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (s1_ctl),
    .coef (mac_coef),
    .samp (mac_samp),
    .acc  (acc),
    .done (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      filtered <= acc;
    end
  end

endmodule

/* test/tb_fir_q15_saturating_per_tap.sv */
`timescale 1ns / 100ps

module tb_fir_q15_saturating_per_tap;

  import fqs_pkg::*;

  localparam int TAPS = TAPS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1600;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_SAMPLE;
  logic [6:0]         tap_index = '0;
  logic signed [15:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] filtered;

  // predictor state
  logic signed [15:0] coef_store [TAPS];
  logic signed [15:0] sample_line [TAPS];
  logic signed [15:0] expected_filtered [$];

  int  bad_results = 0;
  int  clk_ticks = 0;
  int  out_hold = 0;
  bit  no_idle = 1'b0;

  fir_q15_saturating_per_tap u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .tap_index (tap_index),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    clk_ticks++;
    if (clk_ticks >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", clk_ticks);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [15:0] q15_product(logic signed [15:0] a,
                                                     logic signed [15:0] b);
    logic signed [31:0] p;
    if (a == 16'sh8000 && b == 16'sh8000) return 16'sh7fff;
    p = a * b;
    // arithmetic shift by 15 truncates toward minus infinity
    return p[30:15];
  endfunction

  function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                 logic signed [15:0] b);
    logic signed [16:0] s;
    s = a + b;
    if (s > 17'sd32767) return 16'sh7fff;
    if (s < -17'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

  function automatic logic signed [15:0] filter_sample(logic signed [15:0] x);
    logic signed [15:0] acc;
    acc = '0;
    sample_line[0] = x;
    // saturation after every tap, so order 0 .. TAPS-1 matters
    for (int k = 0; k < TAPS; k++)
      acc = sat_add(q15_product(coef_store[k], sample_line[k]), acc);
    for (int k = TAPS - 1; k > 0; k--)
      sample_line[k] = sample_line[k - 1];
    return acc;
  endfunction

  function automatic logic signed [15:0] pick_value(int flavor);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return -16'sd1;
        3: return 16'sd0;
        default: return 16'sd1;
      endcase
    end
    if (flavor == 1) return 16'($signed($urandom_range(0, 511)) - 256);
    return 16'($urandom);
  endfunction

  // one request on the input channel; prediction happens at acceptance
  task automatic send_request(logic req_op, logic [6:0] idx, logic signed [15:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= req_op;
    tap_index <= idx;
    value     <= val;
    do @(posedge clk); while (in_stall);
    if (req_op == OP_LOAD) begin
      if (idx < TAPS) coef_store[idx] = val;
    end else begin
      expected_filtered.push_back(filter_sample(val));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_filtered.size() == 0) begin
          if (bad_results < 10) $display("unexpected output: filtered %0d", filtered);
          bad_results++;
        end else begin
          logic signed [15:0] want;
          want = expected_filtered.pop_front();
          if (filtered !== want) begin
            if (bad_results < 10)
              $display("filtered mismatch: expected %0d, got %0d", want, filtered);
            bad_results++;
          end
        end
        out_hold = no_idle ? 0 : $urandom_range(0, 13);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  task automatic test_zero_coefficients;
    send_request(OP_SAMPLE, 7'd0, 16'sh7fff);
    send_request(OP_SAMPLE, 7'd127, 16'sh8000);
    send_request(OP_SAMPLE, 7'd42, 16'sd0);
  endtask

  task automatic test_product_corners;
    send_request(OP_LOAD, 7'd0, 16'sh8000);
    send_request(OP_SAMPLE, 7'd0, 16'sh8000);
    send_request(OP_SAMPLE, 7'd0, 16'sh7fff);
    send_request(OP_SAMPLE, 7'd0, -16'sd1);
    // negative product rounds down
    send_request(OP_LOAD, 7'd0, 16'sd1);
    send_request(OP_SAMPLE, 7'd0, -16'sd1);
    send_request(OP_LOAD, 7'd0, 16'sh7fff);
    send_request(OP_SAMPLE, 7'd0, 16'sh7fff);
  endtask

  task automatic test_ignored_loads;
    send_request(OP_LOAD, 7'd100, 16'sh7fff);
    send_request(OP_LOAD, 7'd127, 16'sh8000);
    send_request(OP_SAMPLE, 7'd5, 16'sh4000);
  endtask

  task automatic test_accumulator_saturation;
    send_request(OP_LOAD, 7'd1, 16'sh7fff);
    send_request(OP_LOAD, 7'd2, 16'sh8000);
    send_request(OP_LOAD, 7'd99, 16'sh7fff);
    send_request(OP_SAMPLE, 7'd0, 16'sh7fff);
    send_request(OP_SAMPLE, 7'd0, 16'sh7fff);
    send_request(OP_SAMPLE, 7'd0, 16'sh7fff);
    send_request(OP_SAMPLE, 7'd0, 16'sh8000);
  endtask

  task automatic test_random_streams;
    int counted;
    int flavor;
    int n_load;
    int n_samp;
    logic [6:0] idx;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      flavor  = $urandom_range(0, 3);
      // full reload now and then, otherwise a handful of taps
      n_load = (flavor == 0) ? TAPS : $urandom_range(1, 30);
      for (int i = 0; i < n_load; i++) begin
        if (flavor == 0) idx = 7'(i);
        else if ($urandom_range(0, 9) == 0) idx = 7'($urandom_range(TAPS, 127));
        else idx = 7'($urandom_range(0, TAPS - 1));
        send_request(OP_LOAD, idx, pick_value(flavor));
        if (idx < TAPS) counted++;
      end
      n_samp = $urandom_range(5, 40);
      for (int i = 0; i < n_samp; i++) begin
        // occasional load while a result may still be held
        if ($urandom_range(0, 7) == 0) begin
          idx = 7'($urandom_range(0, 127));
          send_request(OP_LOAD, idx, pick_value(flavor));
          if (idx < TAPS) counted++;
        end
        send_request(OP_SAMPLE, 7'($urandom_range(0, 127)), pick_value(flavor));
        counted++;
      end
    end
  endtask

  initial begin
    for (int k = 0; k < TAPS; k++) begin
      coef_store[k]  = '0;
      sample_line[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_coefficients();
    test_product_corners();
    test_ignored_loads();
    test_accumulator_saturation();
    test_random_streams();

    in_valid <= 1'b0;
    no_idle = 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (TAPS + 20) @(posedge clk);

    if (expected_filtered.size() != 0) begin
      $display("%0d expected results never came", expected_filtered.size());
      bad_results++;
    end
    if (bad_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
